// File: src/assert_macros.svh
// Assertion macros used by the stream decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BMP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BMP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bmp_pkg.sv
// Constants and codes for the 24-bit BMP stream decoder.
`timescale 1ns / 1ps

package bmp_pkg;

  localparam int OUT_TDATA_W = 136;

  // parser phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_SIZE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SIGNATURE = 3'd1;
  localparam logic [2:0] ERR_HDR_SIZE  = 3'd2;
  localparam logic [2:0] ERR_FORMAT    = 3'd3;
  localparam logic [2:0] ERR_OFFSET    = 3'd4;

  // byte positions that close a header field
  localparam logic [31:0] POS_SIGNATURE   = 32'd1;
  localparam logic [31:0] POS_OFFSET      = 32'd13;
  localparam logic [31:0] POS_HDR_SIZE    = 32'd17;
  localparam logic [31:0] POS_WIDTH       = 32'd21;
  localparam logic [31:0] POS_HEIGHT      = 32'd25;
  localparam logic [31:0] POS_PLANES      = 32'd27;
  localparam logic [31:0] POS_BPP         = 32'd29;
  localparam logic [31:0] POS_COMPRESSION = 32'd33;
  localparam logic [31:0] POS_IMG_BYTES   = 32'd37;
  localparam logic [31:0] POS_CLR_USED    = 32'd49;
  localparam logic [31:0] POS_CLR_IMPORT  = 32'd53;

  localparam logic [31:0] HEADER_END = 32'd54;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] INFO_HDR_SIZE = 32'd40;
  localparam logic [15:0] BITS_PER_PIX  = 16'd24;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;
  localparam logic [31:0] BYTES_PER_PIX = 32'd3;

endpackage

// File: src/bmp_24bit_stream_decoder.sv
// 24-bit BMP stream decoder: header parse, skip to pixel data, BGR to RGBA packing.
//
// Input stream: one file byte per item on in_tdata; in_tuser high marks byte 0
// of a new file and restarts the parser. Output stream: one result per item at
// most, its kind on out_tuser (pixel, size report, error report), the payload
// on out_tdata, and out_tlast on the final pixel of the image data.
// Errors come on byte 1 (signature), 17 (header size) or 53; else byte 53 gives a
// size report, then skips to the data offset: one pixel per blue, green, red triple.
// After an error or the last pixel, bytes produce nothing until the next start.
//
// Throughput: one byte per cycle unless out_tready stalls the output register. A
// result is on out_tvalid in the cycle after the byte that caused it is accepted.
// Per-byte work is 32-bit compares, increments and a decrement between the state
// registers and the output register.
// Reset: the parser enters the header phase with position and pixel counts cleared;
// the output register is empty. A stalled receiver holds the output register;
// in_tready stays high while that register is empty or being taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp_24bit_stream_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] byte_value
  input  logic                              in_tuser,   // [0] start_of_file
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] error_code, [10:3] red, [18:11] green, [26:19] blue, [34:27] alpha,
  // [66:35] image_width, [98:67] image_height, [130:99] pixel_index, [135:131] 0
  output logic [bmp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [1:0]                        out_tuser,  // [1:0] kind
  output logic                              out_tlast   // last_pixel
);
  import bmp_pkg::*;

  // parser state
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [31:0] left_r, left_nxt;
  logic        fmt_bad_r, fmt_bad_nxt;
  logic [31:0] pix_cnt_r, pix_cnt_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [15:0] held_r, held_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [7:0]  red_r, red_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  alpha_r, alpha_nxt;
  logic [31:0] img_w_r, img_w_nxt;
  logic [31:0] img_h_r, img_h_nxt;
  logic [31:0] pidx_r, pidx_nxt;
  logic        last_r, last_nxt;

  logic        in_accept;
  logic        res_valid;
  logic [1:0]  phase_c;
  logic [31:0] pos_c;
  logic        fmt_bad_c;
  logic [1:0]  bip_c;
  logic [31:0] pix_cnt_c;
  logic [31:0] pos_inc;
  logic [31:0] v32;
  logic [15:0] v16;
  logic        bad_now;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // start of file restarts from the cleared state
  assign phase_c   = in_tuser ? PH_HEADER : phase_r;
  assign pos_c     = in_tuser ? 32'd0 : pos_r;
  assign fmt_bad_c = in_tuser ? 1'b0 : fmt_bad_r;
  assign bip_c     = in_tuser ? 2'd0 : bip_r;
  assign pix_cnt_c = in_tuser ? 32'd0 : pix_cnt_r;

  assign pos_inc = pos_c + 32'd1;
  assign v32     = {in_tdata, shift_r[31:8]};
  assign v16     = v32[31:16];

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    shift_nxt   = shift_r;
    offset_nxt  = offset_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    left_nxt    = left_r;
    fmt_bad_nxt = fmt_bad_r;
    pix_cnt_nxt = pix_cnt_r;
    bip_nxt     = bip_r;
    held_nxt    = held_r;
    bad_now     = 1'b0;

    res_valid = 1'b0;
    kind_nxt  = KIND_PIXEL;
    err_nxt   = ERR_NONE;
    red_nxt   = 8'd0;
    green_nxt = 8'd0;
    blue_nxt  = 8'd0;
    alpha_nxt = 8'd0;
    img_w_nxt = 32'd0;
    img_h_nxt = 32'd0;
    pidx_nxt  = 32'd0;
    last_nxt  = 1'b0;

    if (in_accept) begin
      phase_nxt   = phase_c;
      pos_nxt     = pos_c;
      fmt_bad_nxt = fmt_bad_c;
      bip_nxt     = bip_c;
      pix_cnt_nxt = pix_cnt_c;

      case (phase_c)
        PH_PIXELS: begin
          // left_r counts raw data bytes still to come, this one included
          left_nxt = left_r - 32'd1;
          case (bip_c)
            2'd0: begin
              held_nxt = {8'd0, in_tdata};
              bip_nxt  = 2'd1;
            end
            2'd1: begin
              held_nxt = {in_tdata, held_r[7:0]};
              bip_nxt  = 2'd2;
            end
            default: begin
              res_valid   = 1'b1;
              kind_nxt    = KIND_PIXEL;
              red_nxt     = in_tdata;
              green_nxt   = held_r[15:8];
              blue_nxt    = held_r[7:0];
              alpha_nxt   = ALPHA_OPAQUE;
              pidx_nxt    = pix_cnt_c;
              bip_nxt     = 2'd0;
              pix_cnt_nxt = pix_cnt_c + 32'd1;
              // fewer than a full triple remains after this one
              if (left_r <= BYTES_PER_PIX) begin
                last_nxt  = 1'b1;
                phase_nxt = PH_DONE;
              end
            end
          endcase
        end
        PH_SKIP: begin
          pos_nxt = pos_inc;
          if (pos_inc == offset_r) begin
            phase_nxt = PH_PIXELS;
          end
        end
        PH_HEADER: begin
          pos_nxt   = pos_inc;
          shift_nxt = v32;
          case (pos_c)
            POS_SIGNATURE: begin
              if (v16 != BMP_SIGNATURE) begin
                res_valid = 1'b1;
                kind_nxt  = KIND_ERROR;
                err_nxt   = ERR_SIGNATURE;
                phase_nxt = PH_DONE;
              end
            end
            POS_OFFSET: offset_nxt = v32;
            POS_HDR_SIZE: begin
              if (v32 != INFO_HDR_SIZE) begin
                res_valid = 1'b1;
                kind_nxt  = KIND_ERROR;
                err_nxt   = ERR_HDR_SIZE;
                phase_nxt = PH_DONE;
              end
            end
            POS_WIDTH:       width_nxt = v32;
            POS_HEIGHT:      height_nxt = v32;
            POS_PLANES:      fmt_bad_nxt = fmt_bad_c || (v16 != 16'd1);
            POS_BPP:         fmt_bad_nxt = fmt_bad_c || (v16 != BITS_PER_PIX);
            POS_COMPRESSION: fmt_bad_nxt = fmt_bad_c || (v32 != 32'd0);
            POS_IMG_BYTES:   left_nxt = v32;
            POS_CLR_USED:    fmt_bad_nxt = fmt_bad_c || (v32 != 32'd0);
            POS_CLR_IMPORT: begin
              bad_now     = fmt_bad_c || (v32 != 32'd0);
              fmt_bad_nxt = bad_now;
              res_valid   = 1'b1;
              if (bad_now) begin
                kind_nxt  = KIND_ERROR;
                err_nxt   = ERR_FORMAT;
                phase_nxt = PH_DONE;
              end else if (offset_r < HEADER_END) begin
                kind_nxt  = KIND_ERROR;
                err_nxt   = ERR_OFFSET;
                phase_nxt = PH_DONE;
              end else begin
                kind_nxt  = KIND_SIZE;
                img_w_nxt = width_r;
                img_h_nxt = height_r;
                if (left_r < BYTES_PER_PIX) begin
                  phase_nxt = PH_DONE;
                end else if (offset_r == HEADER_END) begin
                  phase_nxt = PH_PIXELS;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_accept) begin
      out_valid_nxt = res_valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pos_r       <= 32'd0;
      fmt_bad_r   <= 1'b0;
      pix_cnt_r   <= 32'd0;
      bip_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      fmt_bad_r   <= fmt_bad_nxt;
      pix_cnt_r   <= pix_cnt_nxt;
      bip_r       <= bip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r  <= shift_nxt;
    offset_r <= offset_nxt;
    width_r  <= width_nxt;
    height_r <= height_nxt;
    left_r   <= left_nxt;
    held_r   <= held_nxt;
    if (in_accept) begin
      kind_r  <= kind_nxt;
      err_r   <= err_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
      img_w_r <= img_w_nxt;
      img_h_r <= img_h_nxt;
      pidx_r  <= pidx_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {5'd0, pidx_r, img_h_r, img_w_r, alpha_r, blue_r, green_r, red_r,
                       err_r};

  `BMP_ASSERT_IMP(a_last_is_pixel, out_valid_r && last_r, kind_r == KIND_PIXEL,
    "last flag on a non-pixel item")
  `BMP_ASSERT_IMP(a_err_ends_file, out_valid_r && (kind_r == KIND_ERROR),
    phase_r == PH_DONE, "error reported but parser still running")
  `BMP_ASSERT_IMP(a_pixel_opaque, out_valid_r && (kind_r == KIND_PIXEL),
    alpha_r == ALPHA_OPAQUE, "pixel without opaque alpha")
  `BMP_ASSERT_NXT(a_pixel_count_step,
    in_accept && !in_tuser && (phase_r == PH_PIXELS) && (bip_r == 2'd2),
    pix_cnt_r == $past(pix_cnt_r) + 32'd1, "pixel count did not advance")

endmodule
